>>> rtl/core/dnq_pkg.sv
// dnq_pkg: shared sizes, operation and status codes for the notice scheduler
// depends on nothing; used by dedup_notice_queue_with_cooldown_unit
package dnq_pkg;

    // sizes
    localparam int QUEUE_DEPTH = 8;
    localparam int NUM_NOTICES = 128;

    // field widths
    localparam int OP_W     = 2;
    localparam int ID_W     = 7;
    localparam int HOLD_W   = 16;
    localparam int TIME_W   = 32;
    localparam int STATUS_W = 3;
    localparam int QCOUNT_W = 4;

    // derived widths
    localparam int IDX_W = $clog2(NUM_NOTICES);
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    // operation codes; code 3 carries no meaning
    typedef enum logic [OP_W-1:0] {
        OP_POST    = 2'd0,
        OP_SERVICE = 2'd1,
        OP_CLEAR   = 2'd2
    } op_t;

    // result status codes
    typedef enum logic [STATUS_W-1:0] {
        ST_IDLE      = 3'd0,
        ST_STARTED   = 3'd1,
        ST_QUEUED    = 3'd2,
        ST_COOLDOWN  = 3'd3,
        ST_NOSAMPLE  = 3'd4,
        ST_DUPLICATE = 3'd5,
        ST_REFUSED   = 3'd6,
        ST_CLEARED   = 3'd7
    } status_t;

endpackage

>>> rtl/core/dnq_ram.sv
// dnq_ram: generic single-write, single-read memory with registered read data
// depends on nothing; sized by its width and depth parameters
module dnq_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 128
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // write port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // registered read port, holds when not enabled
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

>>> rtl/core/dedup_notice_queue_with_cooldown_unit.sv
// dedup_notice_queue_with_cooldown_unit: notice scheduler top level
// depends on dnq_pkg and dnq_ram (cooldown end time memory)
//
// Usage:
// - input channel (in_valid / in_stall) carries one op per item: post a
//   notice, service the queue, or clear the queue and all cooldowns
// - output channel (out_valid / out_stall) returns one result item per
//   input item: status, started ID and the queue fill after the item
// - the item is registered in the work stage, its result in the result
//   register; the cooldown memory is read as the item is taken, and the
//   decision, memory write-back and queue update follow as it leaves the stage
// - throughput: one item per cycle while out_stall is low; a write-back to
//   the same ID as the next item's read is forwarded, so back-to-back items are exact
// - reset: queue empty, no notice playing, every cooldown end reads as
//   zero (per-ID written bits are cleared, no memory sweep is needed)
// - a clear op records the current turn and drops all written bits, so
//   every cooldown end then reads as that turn
// - when out_stall is held, the finished item waits in the result
//   register, one more item is taken into the work stage, and then
//   in_stall rises until the result is taken
module dedup_notice_queue_with_cooldown_unit (
    input  logic                         clk,
    input  logic                         rst_n,
    // input channel
    input  logic                         in_valid,
    output logic                         in_stall,
    input  logic [dnq_pkg::OP_W-1:0]     operation,
    input  logic [dnq_pkg::ID_W-1:0]     msg_id,
    input  logic [dnq_pkg::HOLD_W-1:0]   holdoff,
    input  logic                         allow_queue,
    input  logic                         player_busy,
    input  logic                         player_accepts,
    input  logic [dnq_pkg::TIME_W-1:0]   now,
    // output channel
    output logic                         out_valid,
    input  logic                         out_stall,
    output logic [dnq_pkg::STATUS_W-1:0] status,
    output logic [dnq_pkg::ID_W-1:0]     start_id,
    output logic [dnq_pkg::QCOUNT_W-1:0] queue_count
);

    localparam int QD = dnq_pkg::QUEUE_DEPTH;
    localparam int NN = dnq_pkg::NUM_NOTICES;

    // handshake and work stage
    logic in_accept, s1_fire, out_fire;
    logic s1_valid_reg, s1_valid_next;
    logic out_valid_reg, out_valid_next;

    // captured item
    dnq_pkg::op_t               s1_op_reg;
    logic [dnq_pkg::ID_W-1:0]   s1_id_reg;
    logic [dnq_pkg::HOLD_W-1:0] s1_hold_reg;
    logic                       s1_q_reg, s1_busy_reg, s1_acc_reg;
    logic [dnq_pkg::TIME_W-1:0] s1_now_reg;
    logic [dnq_pkg::IDX_W-1:0]  s1_addr_reg;

    // cooldown memory and forwarding
    logic                       cd_wr_en;
    logic [dnq_pkg::IDX_W-1:0]  cd_wr_addr;
    logic [dnq_pkg::TIME_W-1:0] cd_wr_data;
    logic [dnq_pkg::IDX_W-1:0]  cd_rd_addr;
    logic [dnq_pkg::TIME_W-1:0] cd_rd_data;
    logic                       byp_hit_reg;
    logic [dnq_pkg::TIME_W-1:0] byp_data_reg;
    logic                       cd_written_reg [NN];
    logic                       cd_written_next [NN];
    logic [dnq_pkg::TIME_W-1:0] clear_time_reg, clear_time_next;

    // queue and player state
    logic [dnq_pkg::ID_W-1:0]   q_id_reg [QD];
    logic [dnq_pkg::ID_W-1:0]   q_id_next [QD];
    logic [dnq_pkg::HOLD_W-1:0] q_hold_reg [QD];
    logic [dnq_pkg::HOLD_W-1:0] q_hold_next [QD];
    logic [dnq_pkg::CNT_W-1:0]  q_count_reg, q_count_next;
    logic [dnq_pkg::ID_W-1:0]   playing_reg, playing_next;

    // result register
    logic [dnq_pkg::STATUS_W-1:0] status_reg, status_next;
    logic [dnq_pkg::ID_W-1:0]     start_id_reg, start_id_next;
    logic [dnq_pkg::QCOUNT_W-1:0] qcount_reg, qcount_next;

    // decision signals
    logic                         pop;
    logic                         post_go;
    logic [dnq_pkg::ID_W-1:0]     p_id;
    logic [dnq_pkg::HOLD_W-1:0]   p_hold;
    logic                         p_q, p_busy, p_acc;
    logic [dnq_pkg::ID_W-1:0]     play_view;
    logic [dnq_pkg::ID_W-1:0]     v_id [QD];
    logic [dnq_pkg::HOLD_W-1:0]   v_hold [QD];
    logic [dnq_pkg::CNT_W-1:0]    v_count;
    logic                         v_holds_id;
    logic [dnq_pkg::TIME_W-1:0]   cd_raw, cd_val;
    logic                         id_oob, in_cooldown;
    logic [dnq_pkg::TIME_W:0]     end_sum;
    logic [dnq_pkg::TIME_W-1:0]   end_sat;
    logic                         push;
    dnq_pkg::status_t             p_status;

    // handshake
    assign s1_fire   = s1_valid_reg && (!out_valid_reg || !out_stall);
    assign in_stall  = s1_valid_reg && out_valid_reg && out_stall;
    assign in_accept = in_valid && !in_stall;
    assign out_fire  = out_valid_reg && !out_stall;

    assign s1_valid_next  = in_accept ? 1'b1 : (s1_fire ? 1'b0 : s1_valid_reg);
    assign out_valid_next = s1_fire ? 1'b1 : (out_fire ? 1'b0 : out_valid_reg);

    // read address: a service op looks up the queue head as it will be
    assign cd_rd_addr = (operation == dnq_pkg::OP_SERVICE) ?
                        q_id_next[0][dnq_pkg::IDX_W-1:0] : msg_id[dnq_pkg::IDX_W-1:0];

    dnq_ram #(
        .WIDTH (dnq_pkg::TIME_W),
        .DEPTH (NN)
    ) u_cooldown_ram (
        .clk     (clk),
        .wr_en   (cd_wr_en),
        .wr_addr (cd_wr_addr),
        .wr_data (cd_wr_data),
        .rd_en   (in_accept),
        .rd_addr (cd_rd_addr),
        .rd_data (cd_rd_data)
    );

    // cooldown end of the posted ID, with forwarding and clear mark
    assign cd_raw = byp_hit_reg ? byp_data_reg : cd_rd_data;
    assign cd_val = cd_written_reg[s1_addr_reg] ? cd_raw : clear_time_reg;

    // which notice is posted: the item's own or the popped queue head
    always_comb
    begin
        pop       = (s1_op_reg == dnq_pkg::OP_SERVICE) && !s1_busy_reg &&
                    (q_count_reg != '0);
        post_go   = (s1_op_reg == dnq_pkg::OP_POST) || pop;
        play_view = ((s1_op_reg == dnq_pkg::OP_SERVICE) && !s1_busy_reg) ?
                    '0 : playing_reg;
        if (pop)
        begin
            p_id   = q_id_reg[0];
            p_hold = q_hold_reg[0];
            p_q    = 1'b1;
            p_busy = 1'b0;
        end
        else
        begin
            p_id   = s1_id_reg;
            p_hold = s1_hold_reg;
            p_q    = s1_q_reg;
            p_busy = s1_busy_reg;
        end
        p_acc = s1_acc_reg;
    end

    // queue as seen by the post, after a possible pop
    always_comb
    begin
        v_count = q_count_reg - dnq_pkg::CNT_W'(pop);
        for (int i = 0; i < QD; i++)
        begin
            if (pop)
            begin
                v_id[i]   = (i + 1 < QD) ? q_id_reg[(i + 1) % QD] : '0;
                v_hold[i] = (i + 1 < QD) ? q_hold_reg[(i + 1) % QD] : '0;
            end
            else
            begin
                v_id[i]   = q_id_reg[i];
                v_hold[i] = q_hold_reg[i];
            end
        end
    end

    // duplicate search over the live queue entries
    always_comb
    begin
        v_holds_id = 1'b0;
        for (int i = 0; i < QD; i++)
        begin
            if ((dnq_pkg::CNT_W'(i) < v_count) && (v_id[i] == p_id))
            begin
                v_holds_id = 1'b1;
            end
        end
    end

    // saturating end time and cooldown test
    assign end_sum     = {1'b0, s1_now_reg} +
                         {{(dnq_pkg::TIME_W-dnq_pkg::HOLD_W+1){1'b0}}, p_hold};
    assign end_sat     = end_sum[dnq_pkg::TIME_W] ? '1 : end_sum[dnq_pkg::TIME_W-1:0];
    assign id_oob      = {1'b0, p_id} >= (dnq_pkg::ID_W+1)'(NN);
    assign in_cooldown = id_oob || (s1_now_reg < cd_val);

    // post decision
    always_comb
    begin
        push = 1'b0;
        if (in_cooldown)
        begin
            p_status = dnq_pkg::ST_COOLDOWN;
        end
        else if (!p_busy && (p_id == '0))
        begin
            p_status = dnq_pkg::ST_NOSAMPLE;
        end
        else if (!p_busy && p_acc)
        begin
            p_status = dnq_pkg::ST_STARTED;
        end
        else if ((p_id == play_view) || v_holds_id)
        begin
            p_status = dnq_pkg::ST_DUPLICATE;
        end
        else if (p_q && (v_count < dnq_pkg::CNT_W'(QD)))
        begin
            p_status = dnq_pkg::ST_QUEUED;
            push     = 1'b1;
        end
        else
        begin
            p_status = dnq_pkg::ST_REFUSED;
        end
    end

    // state update and result
    always_comb
    begin
        q_count_next    = q_count_reg;
        playing_next    = playing_reg;
        clear_time_next = clear_time_reg;
        status_next     = status_reg;
        start_id_next   = start_id_reg;
        cd_wr_en        = 1'b0;
        cd_wr_addr      = p_id[dnq_pkg::IDX_W-1:0];
        cd_wr_data      = end_sat;
        for (int i = 0; i < QD; i++)
        begin
            q_id_next[i]   = q_id_reg[i];
            q_hold_next[i] = q_hold_reg[i];
        end
        for (int n = 0; n < NN; n++)
        begin
            cd_written_next[n] = cd_written_reg[n];
        end

        if (s1_fire)
        begin
            status_next   = dnq_pkg::ST_IDLE;
            start_id_next = '0;
            unique case (s1_op_reg) inside
                dnq_pkg::OP_POST, dnq_pkg::OP_SERVICE:
                begin
                    if ((s1_op_reg == dnq_pkg::OP_SERVICE) && !s1_busy_reg)
                    begin
                        playing_next = '0;
                    end
                    if (post_go)
                    begin
                        status_next  = p_status;
                        q_count_next = v_count + dnq_pkg::CNT_W'(push);
                        for (int i = 0; i < QD; i++)
                        begin
                            if (push && (v_count == dnq_pkg::CNT_W'(i)))
                            begin
                                q_id_next[i]   = p_id;
                                q_hold_next[i] = p_hold;
                            end
                            else
                            begin
                                q_id_next[i]   = v_id[i];
                                q_hold_next[i] = v_hold[i];
                            end
                        end
                        if (p_status == dnq_pkg::ST_STARTED)
                        begin
                            playing_next  = p_id;
                            start_id_next = p_id;
                            cd_wr_en      = 1'b1;
                            cd_written_next[p_id[dnq_pkg::IDX_W-1:0]] = 1'b1;
                        end
                    end
                end
                dnq_pkg::OP_CLEAR:
                begin
                    status_next     = dnq_pkg::ST_CLEARED;
                    q_count_next    = '0;
                    clear_time_next = s1_now_reg;
                    for (int n = 0; n < NN; n++)
                    begin
                        cd_written_next[n] = 1'b0;
                    end
                end
                default:
                begin
                    status_next = dnq_pkg::ST_IDLE;
                end
            endcase
        end
        qcount_next = s1_fire ? dnq_pkg::QCOUNT_W'(q_count_next) : qcount_reg;
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg   <= 1'b0;
            out_valid_reg  <= 1'b0;
            q_count_reg    <= '0;
            playing_reg    <= '0;
            clear_time_reg <= '0;
            for (int n = 0; n < NN; n++)
            begin
                cd_written_reg[n] <= 1'b0;
            end
        end
        else
        begin
            s1_valid_reg   <= s1_valid_next;
            out_valid_reg  <= out_valid_next;
            q_count_reg    <= q_count_next;
            playing_reg    <= playing_next;
            clear_time_reg <= clear_time_next;
            for (int n = 0; n < NN; n++)
            begin
                cd_written_reg[n] <= cd_written_next[n];
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            s1_op_reg    <= dnq_pkg::op_t'(operation);
            s1_id_reg    <= msg_id;
            s1_hold_reg  <= holdoff;
            s1_q_reg     <= allow_queue;
            s1_busy_reg  <= player_busy;
            s1_acc_reg   <= player_accepts;
            s1_now_reg   <= now;
            s1_addr_reg  <= cd_rd_addr;
            byp_hit_reg  <= cd_wr_en && (cd_wr_addr == cd_rd_addr);
            byp_data_reg <= cd_wr_data;
        end
        for (int i = 0; i < QD; i++)
        begin
            q_id_reg[i]   <= q_id_next[i];
            q_hold_reg[i] <= q_hold_next[i];
        end
        status_reg   <= status_next;
        start_id_reg <= start_id_next;
        qcount_reg   <= qcount_next;
    end

    // outputs
    assign out_valid   = out_valid_reg;
    assign status      = status_reg;
    assign start_id    = start_id_reg;
    assign queue_count = qcount_reg;

    // queue fill never passes its depth
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        q_count_reg <= dnq_pkg::CNT_W'(QD))
        else $error("queue count beyond depth");

    // a started result names a real notice, any other result names none
    a_start_id: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (status == dnq_pkg::ST_STARTED) |-> (start_id != '0))
        else $error("started result without an id");

    a_no_start_id: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (status != dnq_pkg::ST_STARTED) |-> (start_id == '0))
        else $error("start id on a result that did not start");

    // a clear leaves the queue empty
    a_clear_empties: assert property (@(posedge clk) disable iff (!rst_n)
        s1_fire && (s1_op_reg == dnq_pkg::OP_CLEAR) |=> (q_count_reg == '0))
        else $error("queue not empty after clear");

endmodule
